// ===== rtl/core/r2h_pkg.sv =====
// Shared types and constants for the RGB to HSL converter.
package r2h_pkg;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned DIV_STEPS = 16;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              flatten_alpha;
  } pixel_t;

  typedef struct packed {
    logic [8:0]  hue;
    logic [15:0] saturation;
    logic [8:0]  lightness_sum;
  } hsl_t;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  typedef struct packed {
    logic [CHAN_W-1:0]    sat_rem;
    logic [CHAN_W-1:0]    sat_den;
    logic [DIV_STEPS-1:0] sat_q;
    logic [CHAN_W-1:0]    hue_rem;
    logic [CHAN_W-1:0]    hue_div;
    logic [DIV_STEPS-1:0] hue_num;
    logic [8:0]           sum;
    logic                 grey;
    logic                 sat_full;
    logic                 neg;
    sector_t              sector;
  } div_t;

endpackage

// ===== rtl/core/r2h_front.sv =====
// Front stages: alpha blend, channel extremes and divider operand setup.
module r2h_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  input  r2h_pkg::pixel_t up_data,
  output logic            up_stall,
  output logic            dn_valid,
  output r2h_pkg::div_t   dn_data,
  input  logic            dn_stall
);
  import r2h_pkg::*;

  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [15:0] s;
    s = p + {8'd0, p[15:8]} + 16'd1;
    return s[15:8];
  endfunction

  logic v1, v2, v3, v4;
  logic st1, st2, st3, st4;

  logic [15:0] p_r, p_g, p_b;
  logic [7:0]  a1, r1, g1, b1;
  logic        flat1;

  logic [7:0] cr, cg, cb;
  logic [7:0] cr_next, cg_next, cb_next;

  sector_t    sector3, sector3_next;
  logic       neg3, neg3_next;
  logic [7:0] mag3, mag3_next;
  logic [7:0] range3, range3_next;
  logic [8:0] sum3, sum3_next;

  div_t       cell_in, cell_in_next;

  logic [7:0]        mx, mn;
  logic signed [8:0] diff;
  logic [8:0]        over;
  logic [7:0]        den;
  logic [13:0]       num;

  assign st4      = v4 & dn_stall;
  assign st3      = v3 & st4;
  assign st2      = v2 & st3;
  assign st1      = v1 & st2;
  assign up_stall = st1;
  assign dn_valid = v4;
  assign dn_data  = cell_in;

  always_comb begin
    if (flat1) begin
      cr_next = (8'd255 - a1) + div255(p_r);
      cg_next = (8'd255 - a1) + div255(p_g);
      cb_next = (8'd255 - a1) + div255(p_b);
    end else begin
      cr_next = r1;
      cg_next = g1;
      cb_next = b1;
    end
  end

  always_comb begin
    mx = cr;
    if (cg > mx) mx = cg;
    if (cb > mx) mx = cb;
    mn = cr;
    if (cg < mn) mn = cg;
    if (cb < mn) mn = cb;
    if (cb == mx) begin
      sector3_next = SECT_BLUE;
      diff = $signed({1'b0, cr}) - $signed({1'b0, cg});
    end else if (cg == mx) begin
      sector3_next = SECT_GREEN;
      diff = $signed({1'b0, cb}) - $signed({1'b0, cr});
    end else begin
      sector3_next = SECT_RED;
      diff = $signed({1'b0, cg}) - $signed({1'b0, cb});
    end
    neg3_next   = diff[8];
    mag3_next   = diff[8] ? 8'(-diff) : diff[7:0];
    range3_next = mx - mn;
    sum3_next   = {1'b0, mx} + {1'b0, mn};
  end

  always_comb begin
    over = 9'd510 - sum3;
    den  = (sum3 <= 9'd255) ? sum3[7:0] : over[7:0];
    num  = {mag3, 6'd0} - {4'd0, mag3, 2'd0};
    cell_in_next.sat_rem  = range3;
    cell_in_next.sat_den  = den;
    cell_in_next.sat_q    = '0;
    cell_in_next.hue_rem  = '0;
    cell_in_next.hue_div  = range3;
    cell_in_next.hue_num  = {2'd0, num};
    cell_in_next.sum      = sum3;
    cell_in_next.grey     = (range3 == 8'd0);
    cell_in_next.sat_full = (range3 == den);
    cell_in_next.neg      = neg3;
    cell_in_next.sector   = sector3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (!st1) v1 <= up_valid;
      if (!st2) v2 <= v1;
      if (!st3) v3 <= v2;
      if (!st4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (!st1 && up_valid) begin
      p_r   <= 16'(up_data.red) * 16'(up_data.alpha);
      p_g   <= 16'(up_data.green) * 16'(up_data.alpha);
      p_b   <= 16'(up_data.blue) * 16'(up_data.alpha);
      a1    <= up_data.alpha;
      r1    <= up_data.red;
      g1    <= up_data.green;
      b1    <= up_data.blue;
      flat1 <= up_data.flatten_alpha;
    end
    if (!st2 && v1) begin
      cr <= cr_next;
      cg <= cg_next;
      cb <= cb_next;
    end
    if (!st3 && v2) begin
      sector3 <= sector3_next;
      neg3    <= neg3_next;
      mag3    <= mag3_next;
      range3  <= range3_next;
      sum3    <= sum3_next;
    end
    if (!st4 && v3) begin
      cell_in <= cell_in_next;
    end
  end

endmodule

// ===== rtl/core/r2h_div_cell.sv =====
// One restoring division step for the saturation and hue quotients.
module r2h_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  input  r2h_pkg::div_t up_data,
  output logic          up_stall,
  output logic          dn_valid,
  output r2h_pkg::div_t dn_data,
  input  logic          dn_stall
);
  import r2h_pkg::*;

  logic       valid;
  div_t       data, data_next;
  logic [8:0] sat_t, hue_t;
  logic [8:0] sat_d, hue_d;
  logic       sat_ge, hue_ge;

  assign up_stall = valid & dn_stall;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_comb begin
    data_next = up_data;
    sat_t  = {up_data.sat_rem, 1'b0};
    sat_ge = sat_t >= {1'b0, up_data.sat_den};
    sat_d  = sat_t - {1'b0, up_data.sat_den};
    hue_t  = {up_data.hue_rem, up_data.hue_num[DIV_STEPS-1]};
    hue_ge = hue_t >= {1'b0, up_data.hue_div};
    hue_d  = hue_t - {1'b0, up_data.hue_div};
    data_next.sat_rem = sat_ge ? sat_d[7:0] : sat_t[7:0];
    data_next.sat_q   = {up_data.sat_q[DIV_STEPS-2:0], sat_ge};
    data_next.hue_rem = hue_ge ? hue_d[7:0] : hue_t[7:0];
    data_next.hue_num = {up_data.hue_num[DIV_STEPS-2:0], hue_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      data <= data_next;
    end
  end

endmodule

// ===== rtl/core/r2h_back.sv =====
// Output stage: hue sector offset, saturation clamp and result register.
module r2h_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  input  r2h_pkg::div_t up_data,
  output logic          up_stall,
  output logic          dn_valid,
  output r2h_pkg::hsl_t dn_data,
  input  logic          dn_stall
);
  import r2h_pkg::*;

  localparam logic [8:0] HUE_GREEN = 9'd120;
  localparam logic [8:0] HUE_BLUE  = 9'd240;
  localparam logic [8:0] HUE_WRAP  = 9'd360;

  logic       valid;
  hsl_t       data, data_next;
  logic [8:0] q9, inc9, base;

  assign up_stall = valid & dn_stall;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_comb begin
    q9   = {3'd0, up_data.hue_num[5:0]};
    inc9 = {8'd0, (up_data.hue_rem != 8'd0)};
    base = (up_data.sector == SECT_BLUE) ? HUE_BLUE : HUE_GREEN;
    case (up_data.sector)
      SECT_RED: begin
        if (up_data.neg && (q9 != 9'd0)) data_next.hue = HUE_WRAP - q9;
        else data_next.hue = q9;
      end
      SECT_GREEN, SECT_BLUE: begin
        if (up_data.neg) data_next.hue = base - q9 - inc9;
        else data_next.hue = base + q9;
      end
      default: data_next.hue = '0;
    endcase
    data_next.saturation    = up_data.sat_full ? 16'hFFFF : up_data.sat_q;
    data_next.lightness_sum = up_data.sum;
    if (up_data.grey) begin
      data_next.hue        = '0;
      data_next.saturation = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      data <= data_next;
    end
  end

endmodule

// ===== rtl/core/rgb_to_hsl_converter.sv =====
// Pipeline: 4 front stages, 16 divider cells and 1 output stage.
// One request per cycle while not stalled; each divider cell retires one quotient bit.
// Every stage holds its own valid bit, so bubbles close up while the output is stalled.
// Reset is synchronous and clears all valid bits; payload registers are not reset.
// Top level of the RGB to HSL converter.
module rgb_to_hsl_converter (
  input  logic            clk,
  input  logic            rst,
  input  logic            pixel_valid,
  input  r2h_pkg::pixel_t pixel,
  output logic            pixel_stall,
  output logic            result_valid,
  output r2h_pkg::hsl_t   result,
  input  logic            result_stall
);
  import r2h_pkg::*;

  logic [DIV_STEPS:0] chain_valid;
  logic [DIV_STEPS:0] chain_stall;
  div_t               chain_data [DIV_STEPS+1];

  r2h_front u_front (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pixel_valid),
    .up_data  (pixel),
    .up_stall (pixel_stall),
    .dn_valid (chain_valid[0]),
    .dn_data  (chain_data[0]),
    .dn_stall (chain_stall[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    r2h_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[i]),
      .up_data  (chain_data[i]),
      .up_stall (chain_stall[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_data  (chain_data[i+1]),
      .dn_stall (chain_stall[i+1])
    );
  end

  r2h_back u_back (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chain_valid[DIV_STEPS]),
    .up_data  (chain_data[DIV_STEPS]),
    .up_stall (chain_stall[DIV_STEPS]),
    .dn_valid (result_valid),
    .dn_data  (result),
    .dn_stall (result_stall)
  );

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.hue < 9'd360))
    else $error("hue out of range");

  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.saturation == 16'd0)) |-> (result.hue == 9'd0))
    else $error("zero saturation with nonzero hue");

  a_stall_origin: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (result_valid && result_stall))
    else $error("input stalled without a stalled result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

// ===== sim/rgb_to_hsl_converter_checker.sv =====
// Checker that predicts each HSL result from accepted pixel requests and compares it.
module rgb_to_hsl_converter_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            pixel_valid,
  input  r2h_pkg::pixel_t pixel,
  input  logic            pixel_stall,
  input  logic            result_valid,
  input  r2h_pkg::hsl_t   result,
  input  logic            result_stall,
  output int              mismatches,
  output int              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import r2h_pkg::*;

  hsl_t hsl_due[$];

  function automatic hsl_t hsl_of_pixel(pixel_t p);
    int r, g, b, a, hi, lo, span, den, sat, hue;
    hsl_t h;
    r = p.red;
    g = p.green;
    b = p.blue;
    a = p.alpha;
    if (p.flatten_alpha) begin
      r = (255 - a) + (a * r) / 255;
      g = (255 - a) + (a * g) / 255;
      b = (255 - a) + (a * b) / 255;
    end
    hi = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    hue = 0;
    sat = 0;
    if (hi != lo) begin
      span = hi - lo;
      den = (hi + lo <= 255) ? hi + lo : 510 - hi - lo;
      sat = (span << 16) / den;
      if (sat > 65535) sat = 65535;
      if (b == hi) begin
        hue = (240 * span + 60 * (r - g)) / span;
      end else if (g == hi) begin
        hue = (120 * span + 60 * (b - r)) / span;
      end else begin
        hue = (60 * (g - b)) / span;
        if (hue < 0) hue += 360;
      end
    end
    h.hue = hue[8:0];
    h.saturation = sat[15:0];
    h.lightness_sum = 9'(hi + lo);
    return h;
  endfunction

  always @(posedge clk) begin
    hsl_t want;
    if (rst) begin
      mismatches = 0;
      outstanding = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (hsl_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: hue %0d sat %0d light %0d", $time,
                   result.hue, result.saturation, result.lightness_sum);
        end else begin
          want = hsl_due.pop_front();
          if (result != want) begin
            mismatches++;
            $display("%0t: expected hue %0d sat %0d light %0d, got hue %0d sat %0d light %0d",
                     $time, want.hue, want.saturation, want.lightness_sum,
                     result.hue, result.saturation, result.lightness_sum);
          end
        end
      end
      if (pixel_valid && !pixel_stall) hsl_due.insert(hsl_due.size(), hsl_of_pixel(pixel));
      outstanding = hsl_due.size();
    end
  end

endmodule

// ===== sim/rgb_to_hsl_converter_test.sv =====
// Top of the RGB to HSL converter test: clock, reset, pixel stimulus, result stalls, verdict.
module rgb_to_hsl_converter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import r2h_pkg::*;

  localparam int ITEMS       = 1400;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN       = 40;

  logic   clk          = 1'b0;
  logic   rst          = 1'b1;
  logic   pixel_valid  = 1'b0;
  pixel_t pixel        = '0;
  logic   pixel_stall;
  logic   result_valid;
  hsl_t   result;
  logic   result_stall = 1'b0;
  logic   pixel_taken  = 1'b0;
  int     mismatches;
  int     outstanding;
  int     calm_left    = 0;

  rgb_to_hsl_converter u_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel        (pixel),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

  rgb_to_hsl_converter_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel        (pixel),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    pixel_taken <= pixel_valid && !pixel_stall;
  end

  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_request(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [7:0] a, input logic f);
    int gap;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = gap_length();
      if ($urandom_range(0, 99) == 0) calm_left = $urandom_range(30, 80);
    end
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel <= '{red: r, green: g, blue: b, alpha: a, flatten_alpha: f};
    pixel_valid <= 1'b1;
    do @(negedge clk); while (!pixel_taken);
  endtask

  initial begin : receiver
    int free;
    int hold;
    forever begin
      if ($urandom_range(0, 9) == 0) free = $urandom_range(50, 150);
      else free = $urandom_range(1, 6);
      hold = gap_length();
      result_stall <= 1'b0;
      repeat (free) @(negedge clk);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] r, g, b, a;
    logic       f;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    send_request(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_request(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    send_request(8'd128, 8'd128, 8'd128, 8'd77, 1'b0);
    send_request(8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
    send_request(8'd0, 8'd255, 8'd0, 8'd255, 1'b0);
    send_request(8'd0, 8'd0, 8'd255, 8'd128, 1'b0);
    send_request(8'd200, 8'd200, 8'd10, 8'd0, 1'b0);
    send_request(8'd10, 8'd200, 8'd200, 8'd0, 1'b0);
    send_request(8'd200, 8'd10, 8'd200, 8'd0, 1'b0);
    send_request(8'd200, 8'd10, 8'd50, 8'd0, 1'b0);
    send_request(8'd255, 8'd0, 8'd1, 8'd0, 1'b0);
    send_request(8'd255, 8'd0, 8'd5, 8'd0, 1'b0);
    send_request(8'd255, 8'd128, 8'd200, 8'd0, 1'b0);
    send_request(8'd200, 8'd55, 8'd100, 8'd0, 1'b0);
    send_request(8'd101, 8'd100, 8'd100, 8'd0, 1'b0);
    send_request(8'd254, 8'd255, 8'd254, 8'd0, 1'b0);
    send_request(8'd30, 8'd180, 8'd90, 8'd0, 1'b1);
    send_request(8'd30, 8'd180, 8'd90, 8'd255, 1'b1);
    send_request(8'd30, 8'd180, 8'd90, 8'd128, 1'b1);
    send_request(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
    send_request(8'd0, 8'd0, 8'd0, 8'd1, 1'b1);
    send_request(8'd255, 8'd0, 8'd0, 8'd200, 1'b1);
    send_request(8'd30, 8'd180, 8'd90, 8'd255, 1'b0);

    repeat (ITEMS) begin
      r = $urandom_range(0, 255);
      g = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
      case ($urandom_range(0, 11))
        0: begin
          g = r;
          b = r;
        end
        1: g = r;
        2: b = g;
        3: b = r;
        4: begin
          r = 8'hFF;
          g = 8'h00;
        end
        5: begin
          g = 8'hFF;
          b = 8'h00;
        end
        6: begin
          b = 8'hFF;
          r = 8'h00;
        end
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0) a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else a = $urandom_range(0, 255);
      f = $urandom_range(0, 1);
      send_request(r, g, b, a, f);
    end

    pixel_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("rgb_to_hsl_converter_test OK");
    end else begin
      $display("rgb_to_hsl_converter_test NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("rgb_to_hsl_converter_test NOT OK");
    $finish;
  end

endmodule
